// File: src/gpsg_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian polar sample generator package
// Shared constants, queue item type and back-end status type.
// ----------------------------------------------------------------------------
`default_nettype none

package gpsg_pkg;

  // Round(2 ln2 * 2^30), scales log2 to -2 ln
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

  // Widths of the internal datapath
  localparam int FRAC_W  = 16;               // uniforms after alignment
  localparam int SUM_W   = 32;               // s = u^2 + v^2, Q0.32
  localparam int LG_STEPS = 16;              // fraction bits of log2
  localparam int W_W     = 22;               // -2 ln s, Q16
  localparam int DIV_W   = 58;               // (W << 36) and its quotient
  localparam int Q_W     = 29;               // sqrt of the quotient, Q10
  localparam int SQ_STEPS = DIV_W / 2;

  // Register indexes
  localparam logic REG_MEAN = 1'b0;
  localparam logic REG_STD  = 1'b1;

  // Item passed from the front to the back
  typedef struct packed {
    logic [FRAC_W-1:0] u;
    logic [FRAC_W-1:0] v;
    logic [SUM_W-1:0]  s;
    logic              neg_first;
    logic              neg_second;
  } q_item_t;

  // Back-end status
  typedef struct packed {
    logic busy;
    logic second;
  } bk_stat_t;

endpackage

`default_nettype wire

// File: src/gaussian_polar_sample_generator_core.sv
// ----------------------------------------------------------------------------
// Gaussian polar sample generator core
// Turns pairs of uniform fractions into pairs of normal deviates (polar method).
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes mean_value (index 0, signed Q8.8) and std_dev (index 1,
//   unsigned Q8.8); write it only while the block is idle. std_dev of zero
//   drops every pair.
//   in channel takes uniform_u, uniform_v and two sign bits. A pair whose
//   s = u^2 + v^2 is zero or at least one is dropped with no result.
//   out channel gives two results per kept pair, first then last_of_pair.
//   The first result comes after log2, divide, square root, scaling and
//   rounding; the second reruns only the scaling and rounding states.
//   The back end takes one pair at a time through its shared units:
//   16 log2 squaring steps, a bit-serial divider for the 58-bit quotient
//   and a bit-serial square root giving a 29-bit root.
//   A front stage and a two-entry queue take new pairs while the back end
//   works; when out_ready is low the result register holds and the back end
//   waits, then the queue and front stall in turn.
//   Reset clears all valid flags and sets both registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_polar_sample_generator_core import gpsg_pkg::*; #(
  parameter int UNIFORM_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [UNIFORM_BITS-1:0] uniform_u,
  input  logic [UNIFORM_BITS-1:0] uniform_v,
  input  logic                    sign_first,
  input  logic                    sign_second,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             sample,
  output logic                    last_of_pair,
  output logic                    clipped,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [15:0]             cfg_data
);

  logic [15:0] mean_value;
  logic [15:0] std_dev;
  logic        push_valid;
  logic        push_ready;
  q_item_t     push_item;
  logic        pop_valid;
  logic        pop_ready;
  q_item_t     pop_item;
  bk_stat_t    stat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_value <= '0;
      std_dev    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MEAN: mean_value <= cfg_data;
        REG_STD:  std_dev    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gpsg_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .uniform_u, .uniform_v,
    .sign_first, .sign_second, .std_dev,
    .push_valid, .push_ready, .push_item
  );

  gpsg_fifo u_fifo (
    .clk, .rst, .push_valid, .push_ready, .push_item,
    .pop_valid, .pop_ready, .pop_item
  );

  gpsg_back u_back (
    .clk, .rst, .pop_valid, .pop_ready, .pop_item, .mean_value, .std_dev,
    .out_valid, .out_ready, .sample, .last_of_pair, .clipped, .stat
  );

  // The back end stays busy on the second deviate while the first waits
  a_first_busy : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_pair) |-> (stat.busy && stat.second))
    else $error("first result pending without back end on second deviate");

  // No result right after reset
  a_reset_quiet : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: src/gpsg_front.sv
// ----------------------------------------------------------------------------
// Gaussian polar sample generator front end
// Accepts uniform pairs, forms s = u^2 + v^2 and drops rejected pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsg_front import gpsg_pkg::*; #(
  parameter int UNIFORM_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [UNIFORM_BITS-1:0] uniform_u,
  input  logic [UNIFORM_BITS-1:0] uniform_v,
  input  logic                    sign_first,
  input  logic                    sign_second,
  input  logic [15:0]             std_dev,
  output logic                    push_valid,
  input  logic                    push_ready,
  output q_item_t                 push_item
);

  logic              st_valid;
  logic [FRAC_W-1:0] st_u;
  logic [FRAC_W-1:0] st_v;
  logic              st_neg_a;
  logic              st_neg_b;
  logic [FRAC_W-1:0] u_al;
  logic [FRAC_W-1:0] v_al;
  logic [SUM_W:0]    s_full;
  logic              reject;
  logic              advance;

  // Align the uniforms to 16 fraction bits (wider inputs: low 16 bits shifted right by the excess)
  if (UNIFORM_BITS <= FRAC_W) begin : g_up
    assign u_al = FRAC_W'({uniform_u, {(FRAC_W - UNIFORM_BITS + 1){1'b0}}} >> 1);
    assign v_al = FRAC_W'({uniform_v, {(FRAC_W - UNIFORM_BITS + 1){1'b0}}} >> 1);
  end else begin : g_down
    assign u_al = uniform_u[FRAC_W-1:0] >> (UNIFORM_BITS - FRAC_W);
    assign v_al = uniform_v[FRAC_W-1:0] >> (UNIFORM_BITS - FRAC_W);
  end

  // Sum of squares and rejection test
  always_comb begin
    s_full  = (SUM_W+1)'(st_u) * (SUM_W+1)'(st_u) + (SUM_W+1)'(st_v) * (SUM_W+1)'(st_v);
    reject  = (s_full == '0) || s_full[SUM_W] || (std_dev == '0);
    advance = st_valid && (reject || push_ready);
  end

  assign in_ready   = !st_valid || advance;
  assign push_valid = st_valid && !reject;
  assign push_item  = '{u: st_u, v: st_v, s: s_full[SUM_W-1:0],
                        neg_first: st_neg_a, neg_second: st_neg_b};

  // Hold one pair in the stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st_u     <= u_al;
      st_v     <= v_al;
      st_neg_a <= sign_first;
      st_neg_b <= sign_second;
    end
  end

endmodule

`default_nettype wire

// File: src/gpsg_fifo.sv
// ----------------------------------------------------------------------------
// Gaussian polar sample generator queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsg_fifo import gpsg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_item,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_item
);

  q_item_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: src/gpsg_back.sv
// ----------------------------------------------------------------------------
// Gaussian polar sample generator back end
// Sequencer for log2, divide, square root, scaling and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsg_back import gpsg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  q_item_t     pop_item,
  input  logic [15:0] mean_value,
  input  logic [15:0] std_dev,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] sample,
  output logic        last_of_pair,
  output logic        clipped,
  output bk_stat_t    stat
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_NORM  = 10'b0000000010,
    S_LOG   = 10'b0000000100,
    S_SCALE = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_SQRT  = 10'b0000100000,
    S_MULZ  = 10'b0001000000,
    S_MULP  = 10'b0010000000,
    S_ROUND = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state;
  logic   second;
  logic [5:0] cnt;

  // Item and working registers
  q_item_t            item;
  logic [4:0]         lg_int;
  logic [LG_STEPS-1:0] lg_frac;
  logic [31:0]        mant;
  logic [SUM_W:0]     rem;
  logic [DIV_W-1:0]   dq;
  logic [DIV_W-1:0]   rx;
  logic [DIV_W-1:0]   res;
  logic [44:0]        z;
  logic [60:0]        p;
  logic signed [37:0] sum;

  // Combinational step values
  logic [4:0]         msb;
  logic [63:0]        sq;
  logic [32:0]        sq_sh;
  logic [W_W:0]       t;
  logic [52:0]        tc;
  logic [SUM_W:0]     r_sh;
  logic               r_ge;
  logic [DIV_W-1:0]   bitv;
  logic [DIV_W-1:0]   trial;
  logic [FRAC_W-1:0]  u_sel;
  logic [61:0]        p_rnd;
  logic [35:0]        mag;
  logic signed [37:0] mean_x;
  logic signed [37:0] mag_x;
  logic               emit_go;

  always_comb begin
    msb = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (item.s[i]) begin
        msb = 5'(i);
      end
    end
    sq    = 64'(mant) * 64'(mant);
    sq_sh = sq[63:31];
    t     = (W_W+1)'(32'd32 << 16) - (W_W+1)'({lg_int, lg_frac});
    tc    = 53'(t) * 53'(TWO_LN2_Q30);
    r_sh  = {rem[SUM_W-1:0], dq[DIV_W-1]};
    r_ge  = (r_sh >= {1'b0, item.s});
    bitv  = DIV_W'(1) << {cnt[4:0], 1'b0};
    trial = res + bitv;
    u_sel = second ? item.v : item.u;
    p_rnd = 62'(p) + 62'(1 << 25);
    mag   = p_rnd[61:26];
    mean_x = 38'(signed'(mean_value));
    mag_x  = signed'({2'b00, mag});
    emit_go = !out_valid || out_ready;
  end

  assign pop_ready = (state == S_IDLE);
  assign stat      = '{busy: (state != S_IDLE), second: second};

  // Sequence one pair through the shared units
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
      cnt    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            state  <= S_NORM;
            second <= 1'b0;
          end
        end
        S_NORM: begin
          state <= S_LOG;
          cnt   <= '0;
        end
        S_LOG: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(LG_STEPS - 1)) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_DIV;
          cnt   <= '0;
        end
        S_DIV: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DIV_W - 1)) begin
            state <= S_SQRT;
            cnt   <= 6'(SQ_STEPS - 1);
          end
        end
        S_SQRT: begin
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            state <= S_MULZ;
          end
        end
        S_MULZ:  state <= S_MULP;
        S_MULP:  state <= S_ROUND;
        S_ROUND: state <= S_EMIT;
        S_EMIT: begin
          if (emit_go) begin
            if (second) begin
              state <= S_IDLE;
            end else begin
              state  <= S_MULZ;
              second <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item <= pop_item;
      end
      S_NORM: begin
        lg_int  <= msb;
        lg_frac <= '0;
        mant    <= item.s << (5'd31 - msb);
      end
      S_LOG: begin
        mant    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
        lg_frac <= {lg_frac[LG_STEPS-2:0], sq_sh[32]};
      end
      S_SCALE: begin
        dq  <= {tc[51:30], 36'd0};
        rem <= '0;
      end
      S_DIV: begin
        rem <= r_ge ? r_sh - {1'b0, item.s} : r_sh;
        dq  <= {dq[DIV_W-2:0], r_ge};
        if (cnt == 6'(DIV_W - 1)) begin
          rx  <= {dq[DIV_W-2:0], r_ge};
          res <= '0;
        end
      end
      S_SQRT: begin
        if (rx >= trial) begin
          rx  <= rx - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
      end
      S_MULZ: begin
        z <= 45'(u_sel) * 45'(res[Q_W-1:0]);
      end
      S_MULP: begin
        p <= 61'(z) * 61'(std_dev);
      end
      S_ROUND: begin
        sum <= (second ? item.neg_second : item.neg_first) ? mean_x - mag_x
                                                            : mean_x + mag_x;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_go) begin
      last_of_pair <= second;
      if (sum > 38'sd32767) begin
        sample  <= 16'h7FFF;
        clipped <= 1'b1;
      end else if (sum < -38'sd32768) begin
        sample  <= 16'h8000;
        clipped <= 1'b1;
      end else begin
        sample  <= sum[15:0];
        clipped <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
